### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package spq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned PRIO_WIDTH    = 16;
   localparam int unsigned OCC_WIDTH     = 5;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [PRIO_WIDTH-1:0]         prio;
   } entry_type;

   // Broadcast to every cell; already qualified by accept and full/empty.
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

`default_nettype wire

### sv/spq_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if;
   import spq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [VALUE_WIDTH-1:0] item_value;
   logic [PRIO_WIDTH-1:0]         item_priority;

   modport source (output valid, output mode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input mode, input item_value, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic signed [VALUE_WIDTH-1:0] out_value;
   logic [PRIO_WIDTH-1:0]         out_priority;
   logic [OCC_WIDTH-1:0]          occupancy;

   modport source (output valid, output status, output out_value, output out_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_value, input out_priority,
                   input occupancy, output ready);
endinterface

`default_nettype wire

### sv/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  spq_pkg::entry_type   new_entry,
   input  logic                 occupied,
   input  logic                 left_keeps,
   input  spq_pkg::entry_type   left_entry,
   input  spq_pkg::entry_type   right_entry,
   output logic                 keeps,
   output spq_pkg::entry_type   entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Stored entry stays put when it sorts at or ahead of the new one.
   assign keeps = occupied && (entry_ff.prio <= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !keeps) begin
         // First cell that moves takes the new entry, the rest shift right.
         entry_in = left_keeps ? new_entry : left_entry;
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

### sv/sorted_priority_queue_core.sv
// Sorted priority queue: a row of DEPTH cells keeps the entries in ascending
// priority order, ties in arrival order. Every request item (insert or remove)
// yields exactly one response item in the cycle after acceptance; all cells compare
// against the incoming priority in parallel and shift in the same cycle, so a new
// request can be accepted every cycle as long as the response is taken. Inserting
// into a full queue reports status full, removing from an empty one status empty;
// neither changes the contents. Occupancy reports the entry count modulo 32.
// Depends on spq_pkg, spq_if and spq_cell.
`default_nettype none

module sorted_priority_queue_core #(
   parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_bus,
   spq_rsp_if.source rsp_bus
);
   import spq_pkg::*;

   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [PRIO_WIDTH-1:0] prio_in;
   logic [OCC_WIDTH-1:0] occ_ff;
   logic [OCC_WIDTH-1:0] occ_in;

   logic         accept;
   logic         is_full;
   logic         is_empty;
   cell_cmd_type cmd;
   entry_type    new_entry;
   entry_type    slot [DEPTH];
   logic         keeps [DEPTH];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_full       = (count_ff == CountWidth'(DEPTH));
   assign is_empty      = (count_ff == '0);

   assign cmd.insert      = accept && (req_bus.mode == MODE_INSERT) && !is_full;
   assign cmd.remove      = accept && (req_bus.mode == MODE_REMOVE) && !is_empty;
   assign new_entry.value = req_bus.item_value;
   assign new_entry.prio  = req_bus.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_keeps;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_keeps = 1'b1;
         assign left_entry = new_entry;
      end else begin : g_mid
         assign left_keeps = keeps[i-1];
         assign left_entry = slot[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = slot[i];
      end else begin : g_inner
         assign right_entry = slot[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .new_entry   (new_entry),
         .occupied    (CountWidth'(i) < count_ff),
         .left_keeps  (left_keeps),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keeps       (keeps[i]),
         .entry       (slot[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      value_in     = value_ff;
      prio_in      = prio_ff;
      occ_in       = occ_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         prio_in      = '0;
         occ_in       = OCC_WIDTH'(count_in);
         priority if (cmd.insert) begin
            status_in = STATUS_INSERTED;
         end else if (cmd.remove) begin
            status_in = STATUS_REMOVED;
            value_in  = slot[0].value;
            prio_in   = slot[0].prio;
         end else if (req_bus.mode == MODE_INSERT) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      value_ff  <= value_in;
      prio_ff   <= prio_in;
      occ_ff    <= occ_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.out_value    = value_ff;
   assign rsp_bus.out_priority = prio_ff;
   assign rsp_bus.occupancy    = occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("entry count exceeds depth");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_EMPTY) |-> (occ_ff == '0))
      else $error("empty status with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_FULL) |-> (occ_ff == OCC_WIDTH'(DEPTH)))
      else $error("full status without full occupancy");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the queue");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CountWidth'(2)) |-> (slot[0].prio <= slot[1].prio))
      else $error("head entries out of order");
`endif

endmodule

`default_nettype wire

### verif/tb_sorted_priority_queue_core.sv
// Self-checking testbench for sorted_priority_queue_core: directed, random and backpressure
// tests against a queue-based predictor of the sorted entry list.
// Depends on spq_pkg, spq_if and the RTL of the block.
`default_nettype none

module tb_sorted_priority_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = DEPTH_DEFAULT;

   typedef struct {
      status_type              status;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [PRIO_WIDTH-1:0]   prio;
      logic [OCC_WIDTH-1:0]    occupancy;
   } queue_result_type;

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue_core #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   entry_type        stored_entries[$];
   queue_result_type pending_results[$];
   int               mismatch_count = 0;
   bit               steady = 1'b0;    // no idling on either side while set
   int               rsp_hold = 0;     // receiver hold-off, in cycles

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Allows well beyond the slowest correct run before declaring a failure.
   initial begin
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   // Applies one accepted request to the shadow list and returns the result it must cause.
   function automatic queue_result_type apply_request(input logic mode,
                                                      input logic signed [VALUE_WIDTH-1:0] value,
                                                      input logic [PRIO_WIDTH-1:0] prio);
      queue_result_type res;
      entry_type        e;
      int               pos;
      res.value = '0;
      res.prio  = '0;
      if (mode == MODE_INSERT) begin
         if (stored_entries.size() >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // ties go behind every entry of equal priority
            pos = 0;
            while (pos < stored_entries.size() && stored_entries[pos].prio <= prio)
               pos++;
            e.value = value;
            e.prio  = prio;
            stored_entries.insert(pos, e);
            res.status = STATUS_INSERTED;
         end
      end else begin
         if (stored_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            e = stored_entries.pop_front();
            res.value  = e.value;
            res.prio   = e.prio;
            res.status = STATUS_REMOVED;
         end
      end
      res.occupancy = OCC_WIDTH'(stored_entries.size());
      return res;
   endfunction

   // Prediction before checking, so an item predicted and answered at one edge stays ordered.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            pending_results.push_back(apply_request(req_if.mode, req_if.item_value,
                                                    req_if.item_priority));
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_if.status, want.status));
               if (rsp_if.out_value !== want.value)
                  report_mismatch($sformatf("out_value %0d, expected %0d",
                                            rsp_if.out_value, want.value));
               if (rsp_if.out_priority !== want.prio)
                  report_mismatch($sformatf("out_priority %0d, expected %0d",
                                            rsp_if.out_priority, want.prio));
               if (rsp_if.occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_if.occupancy, want.occupancy));
            end
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when rsp_hold is set.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic send_item(input logic mode,
                            input logic signed [VALUE_WIDTH-1:0] value,
                            input logic [PRIO_WIDTH-1:0] prio);
      if (!steady && $urandom_range(99) < 12) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.mode          <= mode;
      req_if.item_value    <= value;
      req_if.item_priority <= prio;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [PRIO_WIDTH-1:0] pick_priority();
      case ($urandom_range(9))
         0:          return '0;
         1:          return '1;
         2, 3, 4, 5: return PRIO_WIDTH'($urandom_range(7));  // narrow range gives many ties
         default:    return PRIO_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      // remove from an empty queue
      send_item(MODE_REMOVE, $urandom, PRIO_WIDTH'($urandom));
      send_item(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
      send_item(MODE_INSERT, 32'sh8000_0000, 16'h0000);
      send_item(MODE_INSERT, 32'sh0000_0000, 16'hFFFF);
      send_item(MODE_INSERT, -32'sd1, 16'h0000);
      // equal priorities must leave in arrival order
      for (int i = 0; i < 6; i++)
         send_item(MODE_INSERT, 32'sd100 + i, 16'h0005);
      for (int i = 0; i < 6; i++)
         send_item(MODE_INSERT, $urandom, 16'h8000 >> i);
      // queue is full now: this insert is dropped
      send_item(MODE_INSERT, $urandom, 16'h0001);
      for (int i = 0; i < 3; i++)
         send_item(MODE_REMOVE, $urandom, PRIO_WIDTH'($urandom));
      wait_for_results();
   endtask

   // Segments with different insert ratios drive the queue to both full and empty.
   task automatic test_random_mix();
      int insert_pct;
      for (int seg = 0; seg < 24; seg++) begin
         case ($urandom_range(2))
            0:       insert_pct = 20;
            1:       insert_pct = 50;
            default: insert_pct = 80;
         endcase
         for (int i = 0; i < 40; i++)
            send_item(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                      pick_value(), pick_priority());
         if (seg == 11)
            wait_for_results();
      end
      wait_for_results();
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_output_hold();
      rsp_hold = 300;
      for (int i = 0; i < 30; i++)
         send_item(($urandom_range(99) < 60) ? MODE_INSERT : MODE_REMOVE,
                   pick_value(), pick_priority());
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(($urandom_range(99) < 50) ? MODE_INSERT : MODE_REMOVE,
                   pick_value(), pick_priority());
      wait_for_results();
      steady = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.mode          <= MODE_INSERT;
      req_if.item_value    <= '0;
      req_if.item_priority <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix();
      test_output_hold();
      test_back_to_back();

      wait_for_results();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
